// ===== design/ps2mc_pkg.sv =====
package ps2mc_pkg;

    // Result kinds carried in the event field of every result beat.
    typedef enum logic [1:0] {
        EV_ABSORB = 2'd0,
        EV_ACK    = 2'd1,
        EV_CLICK  = 2'd2,
        EV_MOVE   = 2'd3
    } event_t;

    // Mouse protocol constants.
    localparam logic [7:0] ACK_BYTE  = 8'hFA;
    localparam int         XSIGN_BIT = 4;
    localparam int         YSIGN_BIT = 5;

    // Configuration register indexes.
    localparam int                  CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 8'd1;

    // Reset values of the origin registers.
    localparam logic [8:0] ORIGIN_X_RST = 9'd180;
    localparam logic [8:0] ORIGIN_Y_RST = 9'd101;

    // Width used for text buffer offset arithmetic before truncation to the port field.
    localparam int OFF_W = 20;

endpackage

// ===== design/ps2_mouse_packet_to_text_cursor_top.sv =====
// PS/2 mouse packet decoder driving a text-mode cursor.
//
// The slave stream (s_tvalid/s_tready/s_tdata) takes one mouse byte per beat.
// Every accepted byte produces exactly one result beat on the master stream
// (m_tvalid/m_tready/m_tdata/m_tuser). The first 0xFA byte seen after reset is
// the acknowledge and only reports that event; all other bytes fill a
// three-byte packet. Each stored byte also reports, when valid, the cell one row
// above the remembered cursor cell for restore. A finished packet either reports the
// lowest pressed button or places the cursor at the origin plus dx and minus dy, scaled to a cell.
//
// The result of an accepted byte is registered in the output register at the edge that
// accepts it. Throughput is one byte per cycle while the receiver takes results, set by the
// single output register; all decoding is one shallow pass.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; the next byte then enters in the same
// cycle the waiting result leaves.
//
// Reset clears the acknowledge flag, the packet position and the remembered
// cell, and loads the origins with 180 and 101. The cfg channel is always
// ready; origins should only be written while the stream is idle.
module ps2_mouse_packet_to_text_cursor_top #(
    parameter int SCREEN_COLS = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave stream: tdata[7:0] rx_byte.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    // Master stream: tdata[11:0] restore_offset, [13:12] button_id,
    // [25:14] move_offset, [36:26] pos_x, [47:37] pos_y, [54:48] cursor_col,
    // [59:55] cursor_row, [63:60] zero.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,
    // tuser[1:0] event_res, [2] restore_valid, [7:3] zero.
    output logic [7:0]                     m_tuser,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [8:0]                     cfg_data
);

    localparam int CW    = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int RW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int OFF_W = ps2mc_pkg::OFF_W;

    // Architectural state.
    logic [8:0]    origin_x_reg, origin_y_reg;
    logic          ack_seen_reg, ack_seen_next;
    logic [1:0]    byte_index_reg, byte_index_next;
    logic [7:0]    byte0_reg, byte1_reg;
    logic [CW-1:0] last_col_reg, last_col_next;
    logic [RW-1:0] last_row_reg, last_row_next;

    // Output register.
    logic          out_valid_reg;
    logic [63:0]   out_data_reg, out_data_next;
    logic [7:0]    out_user_reg, out_user_next;

    logic accept;

    // Decode datapath.
    logic [7:0]       rx_byte;
    logic             is_ack;
    logic             pkt_done;
    logic             btn_hit;
    logic [1:0]       btn_id;
    logic signed [10:0] dx, dy, px, py;
    logic [7:0]       col_raw;
    logic [6:0]       row_raw;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    logic [RW-1:0]    last_row_m1;
    logic [OFF_W-1:0] old_off, new_off;
    logic             restore_valid;
    logic [15:0]      col_ext, row_ext;
    ps2mc_pkg::event_t ev;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign rx_byte  = s_tdata;
    assign is_ack   = !ack_seen_reg && (rx_byte == ps2mc_pkg::ACK_BYTE);
    assign pkt_done = (byte_index_reg == 2'd2);
    assign btn_hit  = |byte0_reg[2:0];
    assign btn_id   = byte0_reg[0] ? 2'd0 : (byte0_reg[1] ? 2'd1 : 2'd2);

    // Signed deltas: the sign bits of the first byte extend the 8-bit delta bytes.
    assign dx = {{3{byte0_reg[ps2mc_pkg::XSIGN_BIT]}}, byte1_reg};
    assign dy = {{3{byte0_reg[ps2mc_pkg::YSIGN_BIT]}}, rx_byte};
    assign px = $signed({2'b00, origin_x_reg}) + dx;
    assign py = $signed({2'b00, origin_y_reg}) - dy;

    // Scale to a text cell; positions stay below 768, so bit 10 is only the sign.
    assign col_raw = px[9:2];
    assign row_raw = py[9:3];

    always_comb
    begin
        if (px[10])
            col = '0;
        else if (9'(col_raw) >= 9'(SCREEN_COLS))
            col = CW'(SCREEN_COLS - 1);
        else
            col = CW'(col_raw);

        if (py[10])
            row = '0;
        else if (8'(row_raw) >= 8'(SCREEN_ROWS))
            row = RW'(SCREEN_ROWS - 1);
        else
            row = RW'(row_raw);
    end

    assign new_off = OFF_W'(col) * OFF_W'(2) + OFF_W'(row) * OFF_W'(2 * SCREEN_COLS);

    // The restore cell lies one row above the remembered cell; row zero gives no restore.
    assign last_row_m1   = last_row_reg - RW'(1);
    assign old_off       = OFF_W'(last_col_reg) * OFF_W'(2)
                         + OFF_W'(last_row_m1) * OFF_W'(2 * SCREEN_COLS);
    assign restore_valid = (last_row_reg != '0) && (old_off != '0);

    assign col_ext = 16'(col);
    assign row_ext = 16'(row);

    // Next state and result beat.
    always_comb
    begin
        ack_seen_next   = ack_seen_reg;
        byte_index_next = byte_index_reg;
        last_col_next   = last_col_reg;
        last_row_next   = last_row_reg;
        out_data_next   = '0;
        ev              = ps2mc_pkg::EV_ABSORB;

        if (is_ack)
        begin
            ack_seen_next = 1'b1;
            ev            = ps2mc_pkg::EV_ACK;
        end
        else
        begin
            if (restore_valid)
                out_data_next[11:0] = old_off[11:0];

            if (!pkt_done)
                byte_index_next = byte_index_reg + 2'd1;
            else
            begin
                byte_index_next = 2'd0;
                if (btn_hit)
                begin
                    ev                   = ps2mc_pkg::EV_CLICK;
                    out_data_next[13:12] = btn_id;
                end
                else
                begin
                    ev                   = ps2mc_pkg::EV_MOVE;
                    out_data_next[25:14] = new_off[11:0];
                    out_data_next[36:26] = px;
                    out_data_next[47:37] = py;
                    out_data_next[54:48] = col_ext[6:0];
                    out_data_next[59:55] = row_ext[4:0];
                    last_col_next        = col;
                    last_row_next        = row;
                end
            end
        end

        out_user_next      = '0;
        out_user_next[1:0] = ev;
        out_user_next[2]   = !is_ack && restore_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= ps2mc_pkg::ORIGIN_X_RST;
            origin_y_reg   <= ps2mc_pkg::ORIGIN_Y_RST;
            ack_seen_reg   <= 1'b0;
            byte_index_reg <= 2'd0;
            last_col_reg   <= '0;
            last_row_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ps2mc_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    ps2mc_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                ack_seen_reg   <= ack_seen_next;
                byte_index_reg <= byte_index_next;
                last_col_reg   <= last_col_next;
                last_row_reg   <= last_row_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Packet bytes carry no reset; they are always written before being read.
    always_ff @(posedge clk)
    begin
        if (accept && !is_ack)
        begin
            if (byte_index_reg == 2'd0)
                byte0_reg <= rx_byte;
            if (byte_index_reg == 2'd1)
                byte1_reg <= rx_byte;
        end
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // The packet position only ever counts 0, 1, 2.
    a_byte_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg != 2'd3)
        else $error("packet byte position out of range");

    // Once the acknowledge is seen it is never forgotten.
    a_ack_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ack_seen_reg |=> ack_seen_reg)
        else $error("acknowledge flag dropped");

    // The remembered cell always lies on the screen.
    a_cell_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(last_col_reg) < SCREEN_COLS) && (32'(last_row_reg) < SCREEN_ROWS))
        else $error("remembered cursor cell off screen");

    // An acknowledge result carries nothing else.
    a_ack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_user_reg[1:0] == ps2mc_pkg::EV_ACK))
        |-> (out_data_reg == '0) && !out_user_reg[2])
        else $error("acknowledge result carries data");

    // A byte that completes a packet leaves the packet position at zero.
    a_packet_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_ack && pkt_done) |=> (byte_index_reg == 2'd0))
        else $error("packet position did not wrap");

endmodule
